// ===== src/cvsd_pkg.sv =====
// ----------------------------------------------------------------------------
// cvsd_pkg
// Shared types, register indexes and filter taps for the CVSD decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package cvsd_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_HISTORY = 2'd0;
	localparam logic [1:0] REG_CHARGE  = 2'd1;
	localparam logic [1:0] REG_DECAY   = 2'd2;
	localparam logic [1:0] REG_LEAK    = 2'd3;

	localparam int NTAPS   = 57;
	localparam int NHIST   = NTAPS - 1;
	localparam int QDEPTH  = 4;
	localparam int FIR_SHIFT = 14;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               last_of_byte;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  history_bits;
		logic [15:0] charge_coef;
		logic [15:0] decay_coef;
		logic [15:0] leak_coef;
	} cfg_t;

	// compressed sample handed from decoder to filter
	typedef struct packed {
		logic signed [16:0] sample;
		logic               last;
		logic               clr;
	} comp_item_t;

	// filter taps, symmetric shift-add weights
	localparam logic signed [13:0] TAP_W [NTAPS] = '{
		14'sd8, 14'sd4, -14'sd16, -14'sd32, -14'sd16, 14'sd16, 14'sd64, 14'sd64, -14'sd4,
		-14'sd64, -14'sd128, -14'sd32, 14'sd128, 14'sd128, 14'sd128, -14'sd64, -14'sd256,
		-14'sd256, 14'sd8, 14'sd256, 14'sd512, 14'sd128, -14'sd512, -14'sd1024, -14'sd512,
		14'sd512, 14'sd2048, 14'sd4096, 14'sd4096, 14'sd4096, 14'sd2048, 14'sd512,
		-14'sd512, -14'sd1024, -14'sd512, 14'sd128, 14'sd512, 14'sd256, 14'sd8,
		-14'sd256, -14'sd256, -14'sd64, 14'sd128, 14'sd128, 14'sd128, -14'sd32,
		-14'sd128, -14'sd64, -14'sd4, 14'sd64, 14'sd64, 14'sd16, -14'sd16, -14'sd32,
		-14'sd16, 14'sd4, 14'sd8
	};

endpackage
`default_nettype wire

// ===== src/cvsd_decoder_with_fir_unit.sv =====
// ----------------------------------------------------------------------------
// cvsd_decoder_with_fir_unit
// CVSD byte decoder with compressor and 57-tap smoothing FIR, eight
// samples per byte.
// ----------------------------------------------------------------------------
// channel  | signals                         | moves
// ---------+---------------------------------+------------------------------
// in       | in_valid in_ready in_data       | one byte, one transfer
// out      | out_valid out_ready out_data    | eight samples per byte
// cfg      | cfg_we cfg_idx cfg_wdata        | register write, no wait
//
// decoder: each bit steps through add, leak, step, gain, the compressor divider
// and push; a byte is taken in the idle state
// filter: two taps per cycle; it is the slower side and sets the steady
// byte rate
// a four-entry sample queue lets decoder and filter stall independently
// reset clears all decoder state and the filter history at once
`default_nettype none
module cvsd_decoder_with_fir_unit #(
	parameter int FRAC_BITS = 24
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  wire cvsd_pkg::in_item_t in_data,
	output logic                    out_valid,
	input  wire                     out_ready,
	output cvsd_pkg::out_item_t     out_data,
	input  wire                     cfg_we,
	input  wire [1:0]               cfg_idx,
	input  wire [15:0]              cfg_wdata
);
	import cvsd_pkg::*;

	cfg_t       cfg_q;
	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_empty;
	comp_item_t push_item;
	comp_item_t pop_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.history_bits <= 3'd4;
			cfg_q.charge_coef  <= 16'd65319;
			cfg_q.decay_coef   <= 16'd65352;
			cfg_q.leak_coef    <= 16'd64256;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_HISTORY: cfg_q.history_bits <= cfg_wdata[2:0];
				REG_CHARGE:  cfg_q.charge_coef  <= cfg_wdata;
				REG_DECAY:   cfg_q.decay_coef   <= cfg_wdata;
				REG_LEAK:    cfg_q.leak_coef    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	cvsd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.push(push), .push_item(push_item), .q_full(q_full)
	);

	cvsd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item), .full(q_full),
		.pop(pop), .pop_item(pop_item), .empty(q_empty)
	);

	cvsd_back u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_item(pop_item), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// queue never overrun or underrun
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n) !(push && q_full))
		else $error("push into full queue");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n) !(pop && q_empty))
		else $error("pop from empty queue");
	// a new byte is taken only after the decoder has pushed its last sample
	a_byte_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("decoder took two bytes back to back");

endmodule
`default_nettype wire

// ===== src/cvsd_front.sv =====
// ----------------------------------------------------------------------------
// cvsd_front
// Decodes the bits of one byte: integrator, step adaptation, compressor.
// ----------------------------------------------------------------------------
`default_nettype none
module cvsd_front #(
	parameter int FRAC_BITS = 24
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire cvsd_pkg::cfg_t    cfg,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire cvsd_pkg::in_item_t in_data,
	output logic                   push,
	output cvsd_pkg::comp_item_t   push_item,
	input  wire                    q_full
);
	import cvsd_pkg::*;

	localparam longint SMIN_L = ((longint'(416) <<< FRAC_BITS) + 5000) / 10000;
	localparam longint SMAX_L = ((longint'(10954) <<< FRAC_BITS) + 5000) / 10000;
	localparam logic [31:0] STEP_MIN = SMIN_L[31:0];
	localparam logic [31:0] STEP_MAX = SMAX_L[31:0];
	localparam int PW = (15 + FRAC_BITS > 45) ? 15 + FRAC_BITS : 45;
	localparam int DW = PW + 2;
	localparam logic [DW-1:0] KNEE = DW'(1) << (15 + FRAC_BITS);

	typedef enum logic [2:0] {F_IDLE, F_ADD, F_LEAK, F_STEP, F_GAIN, F_DIV, F_PUSH} fstate_t;

	fstate_t            state_q;
	logic [7:0]         byte_q;
	logic [2:0]         bit_q;
	logic               clr_q;
	logic signed [31:0] integ_q;
	logic [31:0]        step_q;
	logic [3:0]         hist_q;
	logic               charge_q;
	logic [DW-1:0]      rem_q;
	logic [DW-1:0]      den_q;
	logic [14:0]        quo_q;
	logic [3:0]         cnt_q;
	logic               neg_q;

	logic signed [32:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [49:0] mul_p;
	logic               cur_bit;
	logic [3:0]         hist_nx;
	logic               agree;
	logic signed [33:0] add_sum;
	logic signed [33:0] leak_sh;
	logic [31:0]        mag;
	logic [DW-1:0]      rem2;
	logic [31:0]        step_gap;

	assign in_ready = (state_q == F_IDLE);
	assign cur_bit  = byte_q[bit_q];
	assign hist_nx  = {hist_q[2:0], cur_bit};
	assign agree    = (cfg.history_bits <= 3'd3) ?
		(hist_nx[2:0] == 3'b000 || hist_nx[2:0] == 3'b111) :
		(hist_nx == 4'b0000 || hist_nx == 4'b1111);
	assign add_sum  = cur_bit ? (34'(integ_q) + $signed({2'b00, step_q})) :
		(34'(integ_q) - $signed({2'b00, step_q}));
	assign mag      = integ_q[31] ? 32'(-integ_q) : 32'(integ_q);
	assign step_gap = STEP_MAX - step_q;
	assign leak_sh  = mul_p[49:16];
	assign rem2     = {rem_q[DW-2:0], 1'b0};

	// shared multiplier, operands picked by state
	always_comb begin
		mul_a = 33'(integ_q);
		mul_b = $signed({1'b0, cfg.leak_coef});
		unique case (state_q)
			F_STEP: begin
				mul_a = charge_q ? $signed({1'b0, step_gap}) : $signed({1'b0, step_q});
				mul_b = charge_q ? $signed({1'b0, cfg.charge_coef}) :
					$signed({1'b0, cfg.decay_coef});
			end
			F_GAIN: begin
				mul_a = $signed({1'b0, mag});
				mul_b = 17'sd10000;
			end
			default: ;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign push = (state_q == F_PUSH) && !q_full;
	assign push_item.sample = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
	assign push_item.last   = (bit_q == 3'd7);
	assign push_item.clr    = clr_q;

	// bit sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			integ_q  <= '0;
			step_q   <= STEP_MIN;
			hist_q   <= 4'hA;
			clr_q    <= 1'b0;
			bit_q    <= '0;
			byte_q   <= '0;
			charge_q <= 1'b0;
			rem_q    <= '0;
			den_q    <= '0;
			quo_q    <= '0;
			cnt_q    <= '0;
			neg_q    <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: if (in_valid) begin
					byte_q <= in_data.data_byte;
					clr_q  <= in_data.first_byte;
					bit_q  <= '0;
					if (in_data.first_byte) begin
						integ_q <= '0;
						step_q  <= STEP_MIN;
						hist_q  <= 4'hA;
					end
					state_q <= F_ADD;
				end
				F_ADD: begin
					if (add_sum > 34'sh7FFFFFFF) integ_q <= 32'sh7FFFFFFF;
					else if (add_sum < -34'sh80000000) integ_q <= 32'sh80000000;
					else integ_q <= add_sum[31:0];
					hist_q   <= hist_nx;
					charge_q <= agree;
					state_q  <= F_LEAK;
				end
				F_LEAK: begin
					if (leak_sh > 34'sh7FFFFFFF) integ_q <= 32'sh7FFFFFFF;
					else if (leak_sh < -34'sh80000000) integ_q <= 32'sh80000000;
					else integ_q <= leak_sh[31:0];
					state_q <= F_STEP;
				end
				F_STEP: begin
					if (charge_q) step_q <= STEP_MAX - mul_p[47:16];
					else if (mul_p[47:16] < STEP_MIN) step_q <= STEP_MIN;
					else step_q <= mul_p[47:16];
					state_q <= F_GAIN;
				end
				F_GAIN: begin
					rem_q   <= DW'(mul_p[PW-1:0]);
					den_q   <= DW'(mul_p[PW-1:0]) + KNEE;
					neg_q   <= integ_q[31];
					quo_q   <= '0;
					cnt_q   <= '0;
					state_q <= F_DIV;
				end
				// restoring division, one quotient bit per cycle
				F_DIV: begin
					if (rem2 >= den_q) begin
						rem_q <= rem2 - den_q;
						quo_q <= {quo_q[13:0], 1'b1};
					end else begin
						rem_q <= rem2;
						quo_q <= {quo_q[13:0], 1'b0};
					end
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd14) state_q <= F_PUSH;
				end
				F_PUSH: if (!q_full) begin
					clr_q <= 1'b0;
					bit_q <= bit_q + 3'd1;
					state_q <= (bit_q == 3'd7) ? F_IDLE : F_ADD;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/cvsd_queue.sv =====
// ----------------------------------------------------------------------------
// cvsd_queue
// Short queue of compressed samples between decoder and filter.
// ----------------------------------------------------------------------------
`default_nettype none
module cvsd_queue (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	input  wire cvsd_pkg::comp_item_t push_item,
	output logic                     full,
	input  wire                      pop,
	output cvsd_pkg::comp_item_t     pop_item,
	output logic                     empty
);
	import cvsd_pkg::*;

	localparam int AW = $clog2(QDEPTH);

	comp_item_t      mem_q [QDEPTH];
	logic [AW-1:0]   wp_q;
	logic [AW-1:0]   rp_q;
	logic [AW:0]     cnt_q;

	assign full     = (cnt_q == (AW+1)'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_item = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_item;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== src/cvsd_back.sv =====
// ----------------------------------------------------------------------------
// cvsd_back
// 57-tap FIR, two taps a cycle over a rotating history line.
// ----------------------------------------------------------------------------
`default_nettype none
module cvsd_back (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      q_empty,
	input  wire cvsd_pkg::comp_item_t q_item,
	output logic                     pop,
	output logic                     out_valid,
	input  wire                      out_ready,
	output cvsd_pkg::out_item_t      out_data
);
	import cvsd_pkg::*;

	typedef enum logic [1:0] {B_IDLE, B_MAC, B_OUT} bstate_t;

	bstate_t            state_q;
	logic signed [16:0] hist_q [NHIST];
	logic signed [16:0] newest_q;
	logic               last_q;
	logic signed [35:0] acc_q;
	logic [4:0]         k_q;
	logic               ov_q;
	out_item_t          od_q;

	logic [5:0]         ia;
	logic [5:0]         ib;
	logic signed [35:0] mac_sum;
	logic signed [35:0] acc_sh;
	logic               load;

	assign ia = {k_q, 1'b1};
	assign ib = {k_q, 1'b0} + 6'd2;
	assign mac_sum = acc_q + 36'(TAP_W[ia]) * 36'(hist_q[0]) + 36'(TAP_W[ib]) * 36'(hist_q[1]);
	assign acc_sh  = acc_q >>> FIR_SHIFT;
	assign pop  = (state_q == B_IDLE) && !q_empty;
	assign load = (state_q == B_OUT) && (!ov_q || out_ready);
	assign out_valid = ov_q;
	assign out_data  = od_q;

	// filter sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			for (int i = 0; i < NHIST; i++) hist_q[i] <= '0;
			newest_q <= '0;
			last_q   <= 1'b0;
			acc_q    <= '0;
			k_q      <= '0;
			ov_q     <= 1'b0;
			od_q     <= '0;
		end else begin
			if (load) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			unique case (state_q)
				B_IDLE: if (!q_empty) begin
					if (q_item.clr) begin
						for (int i = 0; i < NHIST; i++) hist_q[i] <= '0;
					end
					newest_q <= q_item.sample;
					last_q   <= q_item.last;
					acc_q    <= 36'(TAP_W[0]) * 36'(q_item.sample);
					k_q      <= '0;
					state_q  <= B_MAC;
				end
				B_MAC: begin
					acc_q <= mac_sum;
					for (int i = 0; i < NHIST; i++) hist_q[i] <= hist_q[(i + 2) % NHIST];
					k_q <= k_q + 5'd1;
					if (k_q == 5'(NHIST / 2 - 1)) state_q <= B_OUT;
				end
				B_OUT: if (load) begin
					od_q.last_of_byte <= last_q;
					if (acc_sh > 36'sd32767) od_q.sample <= 16'sh7FFF;
					else if (acc_sh < -36'sd32768) od_q.sample <= 16'sh8000;
					else od_q.sample <= acc_sh[15:0];
					hist_q[0] <= newest_q;
					for (int i = 1; i < NHIST; i++) hist_q[i] <= hist_q[i-1];
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== tb/tb_cvsd_decoder_with_fir_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cvsd_decoder_with_fir_unit
// Drives CVSD bytes through the decoder under several register settings and
// handshake idling patterns. A bit-exact software decoder predicts the eight
// filtered samples of each byte, and every output transfer is checked in order.
// ----------------------------------------------------------------------------
module tb_cvsd_decoder_with_fir_unit;
	import cvsd_pkg::*;

	localparam longint STEP_LO = ((longint'(416) << 24) + 5000) / 10000;
	localparam longint STEP_HI = ((longint'(10954) << 24) + 5000) / 10000;
	localparam int CYCLE_LIMIT = 1000000;

	// predicts decoded samples and holds those still to come out
	class sample_board;
		out_item_t pending_q[$];
		int errors;
		longint hist_bits, charge, decay, leak;
		longint integ, step;
		logic [3:0] bit_hist;
		longint fir_h[NHIST];

		function new();
			errors = 0;
			hist_bits = 4;
			charge = 65319;
			decay = 65352;
			leak = 64256;
			clear_state();
		endfunction

		function void clear_state();
			integ = 0;
			step = STEP_LO;
			bit_hist = 4'hA;
			foreach (fir_h[k]) fir_h[k] = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				REG_HISTORY: hist_bits = val[2:0];
				REG_CHARGE:  charge = val;
				REG_DECAY:   decay = val;
				REG_LEAK:    leak = val;
			endcase
		endfunction

		function longint clamp32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		// soft knee 32768*t/(|t|+32768) on the scaled integrator
		function longint squash(longint v);
			longint mag, num, den, q;
			mag = (v < 0) ? -v : v;
			num = mag * 10000 * 32768;
			den = mag * 10000 + (longint'(32768) << 24);
			q = num / den;
			return (v < 0) ? -q : q;
		endfunction

		function longint smooth(longint newest);
			longint acc;
			acc = longint'(TAP_W[0]) * newest;
			for (int k = 1; k < NTAPS; k++)
				acc += longint'(TAP_W[k]) * fir_h[k-1];
			acc = acc >>> FIR_SHIFT;
			if (acc < -32768) acc = -32768;
			if (acc > 32767) acc = 32767;
			for (int k = NHIST - 1; k > 0; k--)
				fir_h[k] = fir_h[k-1];
			fir_h[0] = newest;
			return acc;
		endfunction

		function void note_byte(in_item_t it);
			longint hb, nxt;
			logic [3:0] mask, agree;
			out_item_t e;
			hb = (hist_bits < 3) ? 3 : ((hist_bits > 4) ? 4 : hist_bits);
			mask = (hb == 3) ? 4'h7 : 4'hF;
			if (it.first_byte) clear_state();
			for (int i = 0; i < 8; i++) begin
				integ = clamp32(it.data_byte[i] ? integ + step : integ - step);
				bit_hist = {bit_hist[2:0], it.data_byte[i]};
				agree = bit_hist & mask;
				integ = clamp32((integ * leak) >>> 16);
				if (agree == 4'h0 || agree == mask) begin
					nxt = STEP_HI - (((STEP_HI - step) * charge) >> 16);
					step = (nxt > STEP_HI) ? STEP_HI : nxt;
				end else begin
					nxt = (step * decay) >> 16;
					step = (nxt < STEP_LO) ? STEP_LO : nxt;
				end
				e.sample = 16'(smooth(squash(integ)));
				e.last_of_byte = (i == 7);
				pending_q.push_back(e);
			end
		endfunction

		function void check_sample(out_item_t got);
			out_item_t e;
			if (pending_q.size() == 0) begin
				$error("unexpected sample %0d", got.sample);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (got.sample !== e.sample) begin
				$error("sample: expected %0d, actual %0d", e.sample, got.sample);
				errors++;
			end
			if (got.last_of_byte !== e.last_of_byte) begin
				$error("last_of_byte: expected %0d, actual %0d", e.last_of_byte,
					got.last_of_byte);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	out_item_t out_data;
	logic cfg_we = 0;
	logic [1:0] cfg_idx = REG_HISTORY;
	logic [15:0] cfg_wdata = '0;

	sample_board board = new();
	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	int hold_cycles = 0;
	int cycles = 0;

	cvsd_decoder_with_fir_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// input transfers feed the predictor
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) board.note_byte(in_data);
	end

	// output transfers are checked; ready follows stall pattern or hold-off
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_sample(out_data);
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("cvsd_decoder_with_fir_unit: mismatch");
			$finish;
		end
	end

	task automatic send_byte(logic [7:0] data, logic first);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{data_byte: data, first_byte: first};
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		board.set_reg(idx, val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// mostly coherent streams: tone-like runs, alternations, rare restarts
	task automatic send_random(int n);
		logic [7:0] run_byte;
		int run_left;
		run_left = 0;
		run_byte = 0;
		for (int i = 0; i < n; i++) begin
			if (run_left == 0 && $urandom_range(3) == 0) begin
				run_left = $urandom_range(12, 2);
				case ($urandom_range(3))
					0: run_byte = 8'hFF;
					1: run_byte = 8'h00;
					2: run_byte = 8'hAA;
					default: run_byte = 8'($urandom);
				endcase
			end
			if (run_left > 0) begin
				run_left--;
				send_byte(run_byte, $urandom_range(31) == 0);
			end else begin
				send_byte(8'($urandom), $urandom_range(15) == 0);
			end
		end
	endtask

	task automatic set_regs(logic [2:0] hb, logic [15:0] ch, logic [15:0] dc,
		logic [15:0] lk);
		write_reg(REG_HISTORY, {13'($urandom), hb});
		write_reg(REG_CHARGE, ch);
		write_reg(REG_DECAY, dc);
		write_reg(REG_LEAK, lk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed bytes at reset settings
		send_byte(8'h00, 1);
		send_byte(8'hFF, 0);
		send_byte(8'hAA, 0);
		send_byte(8'h55, 0);
		repeat (6) send_byte(8'hFF, 0);
		repeat (6) send_byte(8'h00, 0);
		send_byte(8'h0F, 1);
		send_byte(8'hF0, 0);
		send_byte(8'h01, 0);
		send_byte(8'h80, 0);
		drain();

		// history below range, slowest charge, instant decay, almost no leak; no idling
		set_regs(3'd0, 16'hFFFF, 16'h0000, 16'hFFFF);
		repeat (4) send_byte(8'h00, 0);
		repeat (8) send_byte(8'hFF, 0);
		send_random(40);
		drain();

		// history above range, instant charge, slow decay, leak zeroes integrator; sender idle
		snd_idle_pct = 81;
		set_regs(3'd7, 16'h0000, 16'hFFFF, 16'h0000);
		send_random(50);
		drain();

		// three-bit history, random factors; receiver stalls
		snd_idle_pct = 0;
		rcv_stall_pct = 81;
		set_regs(3'd3, 16'($urandom), 16'($urandom), 16'($urandom_range(65535, 60000)));
		send_random(50);
		drain();

		// four-bit history, random factors; both idle
		snd_idle_pct = 15;
		rcv_stall_pct = 15;
		set_regs(3'd4, 16'($urandom), 16'($urandom), 16'($urandom));
		send_random(50);
		drain();

		// reset values, long receiver hold-off to back up the block
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		set_regs(3'd4, 16'd65319, 16'd65352, 16'd64256);
		hold_cycles = 4000;
		send_random(45);
		drain();

		if (board.errors == 0 && board.pending_q.size() == 0) begin
			$display("cvsd_decoder_with_fir_unit: match");
		end else begin
			$display("cvsd_decoder_with_fir_unit: mismatch");
		end
		$finish;
	end
endmodule

// ===== cvsd_decoder_with_fir_unit.f =====
src/cvsd_pkg.sv
src/cvsd_front.sv
src/cvsd_queue.sv
src/cvsd_back.sv
src/cvsd_decoder_with_fir_unit.sv
tb/tb_cvsd_decoder_with_fir_unit.sv
